[hw/rtl/tar_pkg.sv]
// Shared constants and types for the two-adic residue ALU.
// Depends on nothing; imported by every module of the block.
package tar_pkg;

   localparam int NEWTON_STEPS = 6;
   localparam int STEP_LAT     = 4;
   localparam int PIPE_LAT     = STEP_LAT * NEWTON_STEPS;
   localparam int WORD_W       = 64;
   localparam int CMD_W        = 3;
   localparam int SHIFT_W      = 6;
   localparam int REQ_DATA_W   = 144;
   localparam int RSP_DATA_W   = 72;

   localparam logic [WORD_W-1:0]  ZERO_VALUATION = 64'd35536;
   localparam logic [SHIFT_W-1:0] MAX_SHIFT      = 6'd62;
   localparam logic [WORD_W-1:0]  NEWTON_SEED    = 64'd1;
   localparam logic [WORD_W-1:0]  NEWTON_TWO     = 64'd2;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD = 3'd0,
      CMD_MUL = 3'd1,
      CMD_NEG = 3'd2,
      CMD_INV = 3'd3,
      CMD_VAL = 3'd4,
      CMD_DIV = 3'd5
   } cmd_type;

endpackage

[hw/rtl/two_adic_residue_alu.sv]
// Two-adic residue ALU: add, multiply, negate, Newton inverse, valuation, signed divide by 2^n, mod 2^64.
// Every command passes the entry register, 24 Newton stages and the output register.
// Throughput one word per cycle; the whole pipeline holds while the output word is stalled.
// Reset clears all valid bits synchronously; payload registers are not reset.
// Depends on tar_pkg, tar_newton_step and tar_mul.
module two_adic_residue_alu
   import tar_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [2:0] cmd, [66:3] operand_a, [130:67] operand_b, [136:131] shift_count
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [63:0] value, [64] is_unit
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic               en;
   logic               s0_vld_ff;
   logic [CMD_W-1:0]   s0_cmd_ff;
   logic [WORD_W-1:0]  s0_a_ff;
   logic [WORD_W-1:0]  s0_b_ff;
   logic [SHIFT_W-1:0] s0_n_ff;

   logic               vld_ff  [1:PIPE_LAT];
   logic [CMD_W-1:0]   cmd_ff  [1:PIPE_LAT];
   logic               unit_ff [1:PIPE_LAT];
   logic [WORD_W-1:0]  sv_ff   [3:PIPE_LAT];
   logic [WORD_W-1:0]  simp1_ff;
   logic [WORD_W-1:0]  simp2_ff;
   logic [WORD_W-1:0]  simp_in;
   logic [WORD_W-1:0]  sv_in;
   logic [WORD_W-1:0]  mul_p;

   logic [WORD_W-1:0]  chain_a [0:NEWTON_STEPS];
   logic [WORD_W-1:0]  chain_u [0:NEWTON_STEPS];

   logic               rsp_vld_ff;
   logic [WORD_W-1:0]  rsp_val_ff;
   logic               rsp_unit_ff;
   logic [WORD_W-1:0]  val_in;

   logic [6:0]         tz;
   logic [SHIFT_W-1:0] n_sat;
   logic [WORD_W-1:0]  bias;
   logic [WORD_W-1:0]  t_div;

   assign en         = !rsp_vld_ff || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (en) begin
         s0_cmd_ff <= req_tdata[2:0];
         s0_a_ff   <= req_tdata[66:3];
         s0_b_ff   <= req_tdata[130:67];
         s0_n_ff   <= req_tdata[136:131];
      end
   end

   always_comb begin
      tz = 7'd0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (s0_a_ff[i]) tz = 7'(i);
      end
      n_sat = (s0_n_ff > MAX_SHIFT) ? MAX_SHIFT : s0_n_ff;
      bias  = s0_a_ff[WORD_W-1] ? ((64'd1 << n_sat) - 64'd1) : 64'd0;
      t_div = s0_a_ff + bias;
      case (s0_cmd_ff)
         CMD_ADD: simp_in = s0_a_ff + s0_b_ff;
         CMD_NEG: simp_in = 64'd0 - s0_a_ff;
         CMD_VAL: simp_in = (s0_a_ff == 64'd0) ? ZERO_VALUATION : {57'd0, tz};
         CMD_DIV: simp_in = WORD_W'($signed(t_div) >>> n_sat);
         default: simp_in = 64'd0;
      endcase
   end

   tar_mul u_mul (.clock(clock), .en(en), .x(s0_a_ff), .y(s0_b_ff), .p(mul_p));

   assign chain_a[0] = s0_a_ff;
   assign chain_u[0] = NEWTON_SEED;

   for (genvar g = 0; g < NEWTON_STEPS; g++) begin : g_newton
      tar_newton_step u_step (
         .clock(clock), .en(en),
         .a_in(chain_a[g]), .u_in(chain_u[g]),
         .a_out(chain_a[g+1]), .u_out(chain_u[g+1])
      );
   end

   assign sv_in = (cmd_ff[2] == CMD_MUL) ? mul_p : simp2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         simp1_ff   <= simp_in;
         simp2_ff   <= simp1_ff;
         cmd_ff[1]  <= s0_cmd_ff;
         unit_ff[1] <= s0_a_ff[0];
         for (int k = 2; k <= PIPE_LAT; k++) begin
            cmd_ff[k]  <= cmd_ff[k-1];
            unit_ff[k] <= unit_ff[k-1];
         end
         sv_ff[3] <= sv_in;
         for (int k = 4; k <= PIPE_LAT; k++) sv_ff[k] <= sv_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
         for (int k = 1; k <= PIPE_LAT; k++) vld_ff[k] <= 1'b0;
      end else if (en) begin
         s0_vld_ff <= req_tvalid;
         vld_ff[1] <= s0_vld_ff;
         for (int k = 2; k <= PIPE_LAT; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   assign val_in = (cmd_ff[PIPE_LAT] == CMD_INV) ? chain_u[NEWTON_STEPS] : sv_ff[PIPE_LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         rsp_vld_ff <= vld_ff[PIPE_LAT];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_val_ff  <= val_in;
         rsp_unit_ff <= unit_ff[PIPE_LAT];
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {7'd0, rsp_unit_ff, rsp_val_ff};

   a_ready_follows_output: assert property (@(posedge clock)
      req_tready == (!rsp_vld_ff || rsp_tready))
      else $error("input ready does not follow output stall");

   a_reset_clears_output: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output valid after reset");

   a_undefined_cmd_zero: assert property (@(posedge clock) disable iff (reset)
      (en && vld_ff[PIPE_LAT] && (cmd_ff[PIPE_LAT] == 3'd6 || cmd_ff[PIPE_LAT] == 3'd7))
      |=> (rsp_val_ff == 64'd0))
      else $error("undefined command gave a non-zero value");

   a_stall_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      (!en) |=> $stable(vld_ff[PIPE_LAT]) && $stable(s0_vld_ff))
      else $error("pipeline moved while stalled");

endmodule

[hw/rtl/tar_mul.sv]
// Two-stage 64x64 multiplier, low 64 bits of the product.
// Depends on tar_pkg for the word width.
module tar_mul
   import tar_pkg::*;
(
   input  logic              clock,
   input  logic              en,
   input  logic [WORD_W-1:0] x,
   input  logic [WORD_W-1:0] y,
   output logic [WORD_W-1:0] p
);

   logic [63:0] lo_ff;
   logic [31:0] c1_ff;
   logic [31:0] c2_ff;
   logic [63:0] p_ff;
   logic [31:0] c1_in;
   logic [31:0] c2_in;

   always_comb begin
      c1_in = x[31:0] * y[63:32];
      c2_in = x[63:32] * y[31:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lo_ff <= {32'd0, x[31:0]} * {32'd0, y[31:0]};
         c1_ff <= c1_in;
         c2_ff <= c2_in;
         p_ff  <= lo_ff + {c1_ff + c2_ff, 32'd0};
      end
   end

   assign p = p_ff;

endmodule

[hw/rtl/tar_newton_step.sv]
// One Newton step u = u*(2 - a*u) mod 2^64, four register stages.
// Depends on tar_pkg and tar_mul.
module tar_newton_step
   import tar_pkg::*;
(
   input  logic              clock,
   input  logic              en,
   input  logic [WORD_W-1:0] a_in,
   input  logic [WORD_W-1:0] u_in,
   output logic [WORD_W-1:0] a_out,
   output logic [WORD_W-1:0] u_out
);

   logic [WORD_W-1:0] t;
   logic [WORD_W-1:0] w;
   logic [WORD_W-1:0] a_d_ff [STEP_LAT];
   logic [WORD_W-1:0] u_d_ff [2];

   tar_mul u_mul_t (.clock(clock), .en(en), .x(a_in), .y(u_in), .p(t));

   assign w = NEWTON_TWO - t;

   tar_mul u_mul_u (.clock(clock), .en(en), .x(u_d_ff[1]), .y(w), .p(u_out));

   always_ff @(posedge clock) begin
      if (en) begin
         a_d_ff[0] <= a_in;
         for (int k = 1; k < STEP_LAT; k++) a_d_ff[k] <= a_d_ff[k-1];
         u_d_ff[0] <= u_in;
         u_d_ff[1] <= u_d_ff[0];
      end
   end

   assign a_out = a_d_ff[STEP_LAT-1];

endmodule
